@@ rtl/framed_packet_receiver_core_assert.svh @@
// assertion macros used by the receiver core
`ifndef FRAMED_PACKET_RECEIVER_CORE_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_CORE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define FRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("receiver check failed: same-cycle implication");

// condition holds in the cycle after the trigger
`define FRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("receiver check failed: next-cycle implication");

`endif

@@ rtl/frp_pkg.sv @@
`default_nettype none

package frp_pkg;

    // default frame size in bytes, header and check byte included
    localparam int FRAME_BYTES_DEF = 64;

    // framing overhead: two header bytes, source, destination, length, check
    localparam int OVERHEAD = 6;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hBB;
    localparam logic [7:0] BROADCAST  = 8'hFF;

    // byte positions within a frame
    localparam int POS_HUNT    = 0;
    localparam int POS_HDR2    = 1;
    localparam int POS_SRC     = 2;
    localparam int POS_DST     = 3;
    localparam int POS_LEN     = 4;
    localparam int POS_PAYLOAD = 5;

    // payload store write from the parser
    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } t_store_wr;

    // release of a checked frame to the readout side
    typedef struct packed {
        logic       go;
        logic [7:0] src;
        logic [7:0] dst;
    } t_release;

endpackage

`default_nettype wire

@@ rtl/frp_buffer.sv @@
`default_nettype none

module frp_buffer #(
    parameter int STORE_DEPTH = frp_pkg::FRAME_BYTES_DEF - frp_pkg::OVERHEAD,
    parameter int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
    parameter int LW = $clog2(STORE_DEPTH + 1)
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // store write port
    input  frp_pkg::t_store_wr      i_wr,
    input  wire  [AW-1:0]           i_wr_slot,
    // frame release
    input  frp_pkg::t_release       i_rel,
    input  wire  [LW-1:0]           i_rel_len,
    output logic                    o_busy,
    // result channel
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output logic [7:0]              o_source_address,
    output logic [7:0]              o_dest_address,
    output logic [5:0]              o_payload_length,
    output logic                    o_payload_present,
    output logic [5:0]              o_byte_index,
    output logic [7:0]              o_payload_byte,
    output logic                    o_frame_last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [LW-1:0]   r_idx, n_idx;
    logic [LW-1:0]   r_len, n_len;
    logic [7:0]      r_src, n_src;
    logic [7:0]      r_dst, n_dst;
    logic [7:0]      r_rd_data;
    logic [7:0]      r_mem [STORE_DEPTH];

    logic            r_out_valid, n_out_valid;
    logic [7:0]      r_o_src, n_o_src;
    logic [7:0]      r_o_dst, n_o_dst;
    logic [5:0]      r_o_len, n_o_len;
    logic            r_o_present, n_o_present;
    logic [5:0]      r_o_idx, n_o_idx;
    logic [7:0]      r_o_byte, n_o_byte;
    logic            r_o_last, n_o_last;

    logic            w_slot_free;
    logic            w_last;
    logic            w_present;

    // payload store, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_slot] <= i_wr.data;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_present   = (r_len != '0);
    assign w_last      = !w_present || ((r_idx + LW'(1)) == r_len);

    // readout sequencer and output register
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_len       = r_len;
        n_src       = r_src;
        n_dst       = r_dst;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_src     = r_o_src;
        n_o_dst     = r_o_dst;
        n_o_len     = r_o_len;
        n_o_present = r_o_present;
        n_o_idx     = r_o_idx;
        n_o_byte    = r_o_byte;
        n_o_last    = r_o_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_rel.go) begin
                    n_len   = i_rel_len;
                    n_src   = i_rel.src;
                    n_dst   = i_rel.dst;
                    n_idx   = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_o_src     = r_src;
                    n_o_dst     = r_dst;
                    n_o_len     = 6'(r_len);
                    n_o_present = w_present;
                    n_o_idx     = 6'(r_idx);
                    n_o_byte    = w_present ? r_rd_data : 8'h00;
                    n_o_last    = w_last;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + LW'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // frame info and result payload
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_len       <= n_len;
        r_src       <= n_src;
        r_dst       <= n_dst;
        r_o_src     <= n_o_src;
        r_o_dst     <= n_o_dst;
        r_o_len     <= n_o_len;
        r_o_present <= n_o_present;
        r_o_idx     <= n_o_idx;
        r_o_byte    <= n_o_byte;
        r_o_last    <= n_o_last;
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_source_address  = r_o_src;
    assign o_dest_address    = r_o_dst;
    assign o_payload_length  = r_o_len;
    assign o_payload_present = r_o_present;
    assign o_byte_index      = r_o_idx;
    assign o_payload_byte    = r_o_byte;
    assign o_frame_last      = r_o_last;

endmodule

`default_nettype wire

@@ rtl/framed_packet_receiver_core.sv @@
// Framed packet receiver.
// Input channel i_rx_valid / o_rx_ready / i_rx_byte carries one raw link byte
// per transfer. The parser hunts for 0xAA 0xBB, takes source, destination and
// length, stores the payload and checks the XOR byte that closes the frame.
// Destination must be i_cfg_wr_data as last written (reset 1) or 0xFF.
// The parser has no internal wait; it takes a byte whenever o_rx_ready is high.
// A good frame releases one result per payload byte (one result with
// payload_present low for an empty frame) on o_out_valid / i_out_ready.
// For each result the readout first reads the payload store (S_READ), then
// loads the output register (S_LOAD); it starts the next read only after
// that load, so results come one at a time. During the run
// o_rx_ready is low; it rises again once the last result is in the output
// register, so a new byte can be taken while that result still waits.
// A stalled receiver holds the output register and stops the readout.
// Reset clears the parser to header hunt, empties the output register and
// sets the device address to 1; the payload store is not cleared.
`default_nettype none

module framed_packet_receiver_core #(
    parameter int FRAME_BYTES = frp_pkg::FRAME_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration
    input  wire         i_cfg_wr_en,
    input  wire  [7:0]  i_cfg_wr_data,
    // byte input
    input  wire         i_rx_valid,
    output logic        o_rx_ready,
    input  wire  [7:0]  i_rx_byte,
    // results
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_source_address,
    output logic [7:0]  o_dest_address,
    output logic [5:0]  o_payload_length,
    output logic        o_payload_present,
    output logic [5:0]  o_byte_index,
    output logic [7:0]  o_payload_byte,
    output logic        o_frame_last
);

    localparam int STORE_DEPTH = FRAME_BYTES - frp_pkg::OVERHEAD;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LW = $clog2(STORE_DEPTH + 1);
    localparam int PW = $clog2(FRAME_BYTES);

    logic [7:0]         r_device_address;
    logic [PW-1:0]      r_pos, n_pos;
    logic [7:0]         r_xor, n_xor;
    logic [7:0]         r_src, n_src;
    logic [7:0]         r_dst, n_dst;
    logic [LW-1:0]      r_len, n_len;

    logic               w_busy;
    logic               w_rx_fire;
    logic [AW-1:0]      w_slot;
    logic [PW:0]        w_pay_end;
    logic [8:0]         w_len_total;
    frp_pkg::t_store_wr w_wr;
    frp_pkg::t_release  w_rel;

    assign o_rx_ready  = !w_busy;
    assign w_rx_fire   = i_rx_valid && !w_busy;
    assign w_slot      = AW'(r_pos - PW'(frp_pkg::POS_PAYLOAD));
    assign w_pay_end   = (PW+1)'(r_len) + (PW+1)'(frp_pkg::POS_PAYLOAD);
    assign w_len_total = {1'b0, i_rx_byte} + 9'(frp_pkg::OVERHEAD);

    // frame parser
    always_comb begin
        n_pos       = r_pos;
        n_xor       = r_xor;
        n_src       = r_src;
        n_dst       = r_dst;
        n_len       = r_len;
        w_wr.en     = 1'b0;
        w_wr.data   = i_rx_byte;
        w_rel.go    = 1'b0;
        w_rel.src   = r_src;
        w_rel.dst   = r_dst;
        if (w_rx_fire) begin
            if (r_pos == PW'(frp_pkg::POS_HUNT)) begin
                if (i_rx_byte == frp_pkg::HDR_FIRST) begin
                    n_pos = PW'(frp_pkg::POS_HDR2);
                end
            end else if (r_pos == PW'(frp_pkg::POS_HDR2)) begin
                n_pos = (i_rx_byte == frp_pkg::HDR_SECOND) ? PW'(frp_pkg::POS_SRC)
                                                          : PW'(frp_pkg::POS_HUNT);
            end else if (r_pos == PW'(frp_pkg::POS_SRC)) begin
                n_src = i_rx_byte;
                n_xor = i_rx_byte;
                n_pos = PW'(frp_pkg::POS_DST);
            end else if (r_pos == PW'(frp_pkg::POS_DST)) begin
                n_dst = i_rx_byte;
                if (i_rx_byte != r_device_address && i_rx_byte != frp_pkg::BROADCAST) begin
                    n_pos = PW'(frp_pkg::POS_HUNT);
                end else begin
                    n_xor = r_xor ^ i_rx_byte;
                    n_pos = PW'(frp_pkg::POS_LEN);
                end
            end else if (r_pos == PW'(frp_pkg::POS_LEN)) begin
                if (w_len_total > 9'(FRAME_BYTES)) begin
                    n_pos = PW'(frp_pkg::POS_HUNT);
                end else begin
                    n_len = LW'(i_rx_byte);
                    n_xor = r_xor ^ i_rx_byte;
                    n_pos = PW'(frp_pkg::POS_PAYLOAD);
                end
            end else if ((PW+1)'(r_pos) < w_pay_end) begin
                // payload byte into the store
                w_wr.en = 1'b1;
                n_xor   = r_xor ^ i_rx_byte;
                n_pos   = r_pos + PW'(1);
            end else begin
                // check byte closes the frame
                w_rel.go = (r_xor == i_rx_byte);
                n_pos    = PW'(frp_pkg::POS_HUNT);
            end
        end
    end

    // parser state and device address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= 8'h01;
            r_pos            <= PW'(frp_pkg::POS_HUNT);
            r_xor            <= 8'h00;
            r_src            <= 8'h00;
            r_dst            <= 8'h00;
            r_len            <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_device_address <= i_cfg_wr_data;
            end
            r_pos <= n_pos;
            r_xor <= n_xor;
            r_src <= n_src;
            r_dst <= n_dst;
            r_len <= n_len;
        end
    end

    // payload store and readout
    frp_buffer #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW),
        .LW          (LW)
    ) u_buffer (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_wr              (w_wr),
        .i_wr_slot         (w_slot),
        .i_rel             (w_rel),
        .i_rel_len         (r_len),
        .o_busy            (w_busy),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_source_address  (o_source_address),
        .o_dest_address    (o_dest_address),
        .o_payload_length  (o_payload_length),
        .o_payload_present (o_payload_present),
        .o_byte_index      (o_byte_index),
        .o_payload_byte    (o_payload_byte),
        .o_frame_last      (o_frame_last)
    );

`include "framed_packet_receiver_core_assert.svh"

    // a released frame stalls input and leaves the parser hunting
    `FRP_ASSERT_NEXT(a_release_stalls, i_clk, i_rst_n, w_rel.go, w_busy && (r_pos == '0))
    // in the payload phase the stored length fits the frame
    `FRP_ASSERT_IMPLY(a_len_fits, i_clk, i_rst_n, (int'(r_pos) >= frp_pkg::POS_PAYLOAD), (int'(r_len) + frp_pkg::OVERHEAD <= FRAME_BYTES))
    // the position never passes the check byte slot
    `FRP_ASSERT_IMPLY(a_pos_bound, i_clk, i_rst_n, (int'(r_pos) >= frp_pkg::POS_PAYLOAD), (int'(r_pos) <= int'(r_len) + frp_pkg::POS_PAYLOAD))
    // an empty frame result is the last and carries a zero byte
    `FRP_ASSERT_IMPLY(a_empty_result, i_clk, i_rst_n, o_out_valid && !o_payload_present, o_frame_last && (o_payload_byte == 8'h00) && (o_byte_index == 6'd0))

endmodule

`default_nettype wire
